// File: rtl/assert_macros.svh
// Assertion macros shared by the positioner RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define XYSHP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define XYSHP_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/xyshp_pkg.sv
// Shared types, constants and the coil pattern function for the positioner.
// No dependencies.
package xyshp_pkg;

	localparam int POS_W = 16;
	localparam int PERIOD_W = 16;
	localparam int PEN_W = 10;
	localparam int PHASE_W = 3;
	localparam int COIL_W = 4;
	localparam int CFG_IDX_W = 2;

	// bit i is the coil level at phase i: phases 0, 1 and 7 are on
	localparam logic [7:0] COIL_PATTERN = 8'b1000_0011;
	localparam logic [PHASE_W-1:0] OFF_B = 3'd6;
	localparam logic [PHASE_W-1:0] OFF_C = 3'd4;
	localparam logic [PHASE_W-1:0] OFF_D = 3'd2;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_TARGET = 2'd1,
		ACT_PEN    = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS_PERIOD = 2'd0,
		REG_PEN_PERIOD  = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		action_t            action;
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic [PEN_W-1:0]   pen_steps;
		logic               pen_down;
	} item_t;

	typedef struct packed {
		logic [COIL_W-1:0]  x_coils;
		logic [COIL_W-1:0]  y_coils;
		logic [COIL_W-1:0]  pen_coils;
		logic signed [15:0] position_x;
		logic signed [15:0] position_y;
		logic               busy_res;
	} res_t;

	// Coil bits for one half step at the given phase; reverse flips pin order.
	function automatic logic [COIL_W-1:0] coil_bits(input logic [PHASE_W-1:0] ph,
		input logic fwd);
		logic a, b, c, d;
		a = COIL_PATTERN[ph];
		b = COIL_PATTERN[PHASE_W'(ph + OFF_B)];
		c = COIL_PATTERN[PHASE_W'(ph + OFF_C)];
		d = COIL_PATTERN[PHASE_W'(ph + OFF_D)];
		return fwd ? {d, c, b, a} : {a, b, c, d};
	endfunction

endpackage

// File: rtl/xyshp_core.sv
// Positioner state, step pacing and coil update for one accepted item per cycle.
// Depends on xyshp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xyshp_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [xyshp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [xyshp_pkg::PERIOD_W-1:0]       cfg_data,
	input  logic                                 accept,
	input  xyshp_pkg::item_t                     item,
	output xyshp_pkg::res_t                      res
);

	logic [xyshp_pkg::PERIOD_W-1:0] axis_per_q, pen_per_q;
	logic [xyshp_pkg::PHASE_W-1:0]  phase_x_q, phase_y_q, phase_p_q;
	logic [xyshp_pkg::PHASE_W-1:0]  phase_x_d, phase_y_d, phase_p_d;
	logic signed [xyshp_pkg::POS_W-1:0] pos_x_q, pos_y_q, goal_x_q, goal_y_q;
	logic signed [xyshp_pkg::POS_W-1:0] pos_x_d, pos_y_d, goal_x_d, goal_y_d;
	logic [xyshp_pkg::PEN_W-1:0]    pen_rem_q, pen_rem_d;
	logic                           pen_dir_q, pen_dir_d;
	logic [xyshp_pkg::PERIOD_W-1:0] tick_q, tick_d;
	logic [xyshp_pkg::COIL_W-1:0]   coil_x_q, coil_y_q, coil_p_q;
	logic [xyshp_pkg::COIL_W-1:0]   coil_x_d, coil_y_d, coil_p_d;

	logic                           x_pend, y_pend, p_pend, fwd_x, fwd_y;
	logic [xyshp_pkg::PERIOD_W-1:0] period, eff_period;
	logic [xyshp_pkg::PERIOD_W:0]   tick_inc;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_per_q <= xyshp_pkg::PERIOD_RESET;
			pen_per_q  <= xyshp_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				xyshp_pkg::REG_AXIS_PERIOD: axis_per_q <= cfg_data;
				xyshp_pkg::REG_PEN_PERIOD:  pen_per_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign x_pend = (pos_x_q != goal_x_q);
	assign y_pend = (pos_y_q != goal_y_q);
	assign p_pend = (pen_rem_q != '0);
	assign fwd_x  = (goal_x_q > pos_x_q);
	assign fwd_y  = (goal_y_q > pos_y_q);

	assign period     = (!x_pend && !y_pend) ? pen_per_q : axis_per_q;
	assign eff_period = (period == '0) ? xyshp_pkg::PERIOD_W'(1) : period;
	assign tick_inc   = {1'b0, tick_q} + (xyshp_pkg::PERIOD_W+1)'(1);

	always_comb begin
		phase_x_d = phase_x_q;
		phase_y_d = phase_y_q;
		phase_p_d = phase_p_q;
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		goal_x_d  = goal_x_q;
		goal_y_d  = goal_y_q;
		pen_rem_d = pen_rem_q;
		pen_dir_d = pen_dir_q;
		tick_d    = tick_q;
		coil_x_d  = coil_x_q;
		coil_y_d  = coil_y_q;
		coil_p_d  = coil_p_q;
		unique case (item.action)
			xyshp_pkg::ACT_TARGET: begin
				goal_x_d = xyshp_pkg::POS_W'(item.target_x);
				goal_y_d = xyshp_pkg::POS_W'(item.target_y);
			end
			xyshp_pkg::ACT_PEN: begin
				pen_rem_d = item.pen_steps;
				pen_dir_d = item.pen_down;
			end
			xyshp_pkg::ACT_TICK: begin
				if (!x_pend && !y_pend && !p_pend) begin
					tick_d = '0;
				end else begin
					if (tick_q == '0) begin
						// X first, then Y, then pen
						if (x_pend) begin
							coil_x_d  = xyshp_pkg::coil_bits(phase_x_q, fwd_x);
							phase_x_d = phase_x_q + xyshp_pkg::PHASE_W'(1);
							pos_x_d   = fwd_x ? pos_x_q + xyshp_pkg::POS_W'(1)
							                  : pos_x_q - xyshp_pkg::POS_W'(1);
						end else if (y_pend) begin
							coil_y_d  = xyshp_pkg::coil_bits(phase_y_q, fwd_y);
							phase_y_d = phase_y_q + xyshp_pkg::PHASE_W'(1);
							pos_y_d   = fwd_y ? pos_y_q + xyshp_pkg::POS_W'(1)
							                  : pos_y_q - xyshp_pkg::POS_W'(1);
						end else begin
							coil_p_d  = xyshp_pkg::coil_bits(phase_p_q, pen_dir_q);
							phase_p_d = phase_p_q + xyshp_pkg::PHASE_W'(1);
							pen_rem_d = pen_rem_q - xyshp_pkg::PEN_W'(1);
						end
					end
					tick_d = (tick_inc >= {1'b0, eff_period}) ? '0
					                                          : tick_inc[xyshp_pkg::PERIOD_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_x_q <= '0;
			phase_y_q <= '0;
			phase_p_q <= '0;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			goal_x_q  <= '0;
			goal_y_q  <= '0;
			pen_rem_q <= '0;
			pen_dir_q <= 1'b0;
			tick_q    <= '0;
			coil_x_q  <= '0;
			coil_y_q  <= '0;
			coil_p_q  <= '0;
		end else if (accept) begin
			phase_x_q <= phase_x_d;
			phase_y_q <= phase_y_d;
			phase_p_q <= phase_p_d;
			pos_x_q   <= pos_x_d;
			pos_y_q   <= pos_y_d;
			goal_x_q  <= goal_x_d;
			goal_y_q  <= goal_y_d;
			pen_rem_q <= pen_rem_d;
			pen_dir_q <= pen_dir_d;
			tick_q    <= tick_d;
			coil_x_q  <= coil_x_d;
			coil_y_q  <= coil_y_d;
			coil_p_q  <= coil_p_d;
		end
	end

	// Result reflects the state after this item
	always_comb begin
		res.x_coils    = coil_x_d;
		res.y_coils    = coil_y_d;
		res.pen_coils  = coil_p_d;
		res.position_x = 16'(pos_x_d);
		res.position_y = 16'(pos_y_d);
		res.busy_res   = (pos_x_d != goal_x_d) || (pos_y_d != goal_y_d) || (pen_rem_d != '0);
	end

	`XYSHP_ASSERT(a_pos_x_unit, clk, arst_n, (pos_x_q != $past(pos_x_q)) |-> (phase_x_q == $past(phase_x_q) + xyshp_pkg::PHASE_W'(1)), "X moved without phase advance")
	`XYSHP_ASSERT(a_one_motor, clk, arst_n, (pos_x_q != $past(pos_x_q)) |-> (pos_y_q == $past(pos_y_q) && pen_rem_q == $past(pen_rem_q)), "more than one motor stepped")

endmodule

// File: rtl/xyshp_outbuf.sv
// Result register with a skid stage that takes one more item under output stall.
// Depends on xyshp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xyshp_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  xyshp_pkg::res_t  push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output xyshp_pkg::res_t  out_data
);

	logic            main_v_q, skid_v_q;
	xyshp_pkg::res_t main_q, skid_q;
	logic            pop;

	assign pop       = main_v_q && !out_stall;
	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	`XYSHP_NEVER(a_skid_without_main, clk, arst_n, skid_v_q && !main_v_q, "skid holds data while output is empty")
	`XYSHP_NEVER(a_push_when_full, clk, arst_n, push && skid_v_q, "transfer taken while buffer full")
	`XYSHP_ASSERT(a_skid_drains, clk, arst_n, (skid_v_q && pop) |=> (main_v_q && main_q == $past(skid_q)), "skid entry lost")

endmodule

// File: rtl/xy_stepper_half_step_positioner_unit.sv
// Top level of the XY table and pen half-step positioner.
// Depends on xyshp_pkg, xyshp_core and xyshp_outbuf.
// Results are registered in a two-entry output buffer of main and skid entries.
// Throughput: one item per cycle unless in_stall; the skid entry holds an extra result.
// Reset: asynchronous, clears positions, goals, phases, coils and the tick counter;
// both step periods return to 2.
module xy_stepper_half_step_positioner_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [xyshp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [xyshp_pkg::PERIOD_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            action,
	input  logic signed [15:0]                    target_x,
	input  logic signed [15:0]                    target_y,
	input  logic [xyshp_pkg::PEN_W-1:0]           pen_steps,
	input  logic                                  pen_down,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [xyshp_pkg::COIL_W-1:0]          x_coils,
	output logic [xyshp_pkg::COIL_W-1:0]          y_coils,
	output logic [xyshp_pkg::COIL_W-1:0]          pen_coils,
	output logic signed [15:0]                    position_x,
	output logic signed [15:0]                    position_y,
	output logic                                  busy_res
);

	xyshp_pkg::item_t item;
	xyshp_pkg::res_t  res, out_res;
	logic             accept, full;

	assign accept   = in_valid && !full;
	assign in_stall = full;

	always_comb begin
		item.action    = xyshp_pkg::action_t'(action);
		item.target_x  = target_x;
		item.target_y  = target_y;
		item.pen_steps = pen_steps;
		item.pen_down  = pen_down;
	end

	xyshp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.res       (res)
	);

	xyshp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign x_coils    = out_res.x_coils;
	assign y_coils    = out_res.y_coils;
	assign pen_coils  = out_res.pen_coils;
	assign position_x = out_res.position_x;
	assign position_y = out_res.position_y;
	assign busy_res   = out_res.busy_res;

endmodule
